[sv/bpa_pkg.sv]
// shared types, constants and helpers for the bitmap page allocator
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int FUNC_W    = 2;
  localparam int PAGE_W    = 15;
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;

  localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

  typedef enum logic [FUNC_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // index of the lowest clear bit, zero when the word is full
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

[sv/bitmap_page_allocator.sv]
// bitmap page allocator: used/free bitmap and full-word summary in two rams
// free and reserve: the request passes S_RMW and then S_RESP before out_valid rises
// allocate: S_SCAN reads the summary words, one per cycle, then S_WORD and S_RESP
// (straight to S_RESP if none is free), scanning at most ceil(NUM_WORDS/32) words
// one request in flight at a time; a waiting result does not block the next accept
// reset clears both rams to all ones, with in_ready low until every word is written
`timescale 1ns / 1ps

module bitmap_page_allocator #(
  parameter int NUM_WORDS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bpa_pkg::FUNC_W-1:0]    func,
  input  logic [bpa_pkg::PAGE_W-1:0]    page,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bpa_pkg::PAGE_W-1:0]    granted_page,
  output logic                          found
);

  localparam int AW  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SW  = (NUM_WORDS + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
  localparam int SAW = (SW > 1) ? $clog2(SW) : 1;
  localparam int BW  = bpa_pkg::BIT_W;
  localparam int DW  = bpa_pkg::WORD_BITS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WORD,
    S_RMW,
    S_RESP
  } state_t;

  state_t state;

  logic [AW-1:0]              clr;
  logic [SAW-1:0]             scan_addr;
  logic [SAW-1:0]             chk_addr;
  logic                       chk_valid;
  logic                       op_free;
  logic [AW-1:0]              w_addr;
  logic [BW-1:0]              bit_sel;
  logic [SAW-1:0]             s_addr;
  logic [BW-1:0]              sbit;
  logic [DW-1:0]              sum_hold;
  logic [bpa_pkg::PAGE_W-1:0] res_page;
  logic                       res_found;

  logic                       bm_we;
  logic [AW-1:0]              bm_waddr;
  logic [DW-1:0]              bm_wdata;
  logic [AW-1:0]              bm_raddr;
  logic [DW-1:0]              bm_rdata;
  logic                       sum_we;
  logic [SAW-1:0]             sum_waddr;
  logic [DW-1:0]              sum_wdata;
  logic [SAW-1:0]             sum_raddr;
  logic [DW-1:0]              sum_rdata;

  logic                       in_fire;
  logic [AW-1:0]              page_word;
  logic [SAW-1:0]             page_sidx;
  logic                       page_ok;
  logic                       sum_hit;
  logic [BW-1:0]              sum_k;
  logic [SAW+BW-1:0]          hit_cat;
  logic [AW-1:0]              hit_word;
  logic [BW-1:0]              word_k;
  logic [AW+BW-1:0]           pg_cat;
  logic [DW-1:0]              alloc_word;
  logic [DW-1:0]              rmw_word;
  logic [DW-1:0]              new_word;
  logic [DW-1:0]              sum_base;
  logic [DW-1:0]              smask;
  logic                       clr_in_sum;
  logic                       last_sum;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;

  assign page_word = AW'(page >> BW);
  assign page_sidx = SAW'(page_word >> BW);
  assign page_ok   = (32'(page >> BW) < 32'(NUM_WORDS));

  assign sum_hit   = chk_valid && (sum_rdata != bpa_pkg::FULL_WORD);
  assign sum_k     = bpa_pkg::lowest_zero(sum_rdata);
  assign hit_cat   = {chk_addr, sum_k};
  assign hit_word  = hit_cat[AW-1:0];
  assign last_sum  = (chk_addr == SAW'(SW - 1));

  assign word_k     = bpa_pkg::lowest_zero(bm_rdata);
  assign pg_cat     = {w_addr, word_k};
  assign alloc_word = bm_rdata | (DW'(1) << word_k);
  assign rmw_word   = op_free ? (bm_rdata & ~(DW'(1) << bit_sel))
                              : (bm_rdata | (DW'(1) << bit_sel));
  assign new_word   = (state == S_WORD) ? alloc_word : rmw_word;
  assign sum_base   = (state == S_WORD) ? sum_hold : sum_rdata;
  assign smask      = DW'(1) << sbit;
  assign clr_in_sum = (32'(clr) < 32'(SW));

  always_comb begin
    bm_we     = (state == S_CLEAR) || (state == S_WORD) || (state == S_RMW);
    bm_waddr  = (state == S_CLEAR) ? clr : w_addr;
    bm_wdata  = (state == S_CLEAR) ? bpa_pkg::FULL_WORD : new_word;
    bm_raddr  = (state == S_SCAN) ? hit_word : page_word;
    sum_we    = ((state == S_CLEAR) && clr_in_sum) || (state == S_WORD) || (state == S_RMW);
    sum_waddr = (state == S_CLEAR) ? SAW'(clr) : s_addr;
    if (state == S_CLEAR) begin
      sum_wdata = bpa_pkg::FULL_WORD;
    end else if (new_word == bpa_pkg::FULL_WORD) begin
      sum_wdata = sum_base | smask;
    end else begin
      sum_wdata = sum_base & ~smask;
    end
    sum_raddr = (state == S_SCAN) ? scan_addr : page_sidx;
  end

  bpa_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  bpa_ram #(
    .WIDTH (DW),
    .DEPTH (SW)
  ) u_summary (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == AW'(NUM_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            if (func == bpa_pkg::OP_ALLOC) begin
              scan_addr <= '0;
              chk_valid <= 1'b0;
              state     <= S_SCAN;
            end else if ((func == bpa_pkg::OP_FREE || func == bpa_pkg::OP_RESERVE)
                         && page_ok) begin
              op_free <= (func == bpa_pkg::OP_FREE);
              w_addr  <= page_word;
              bit_sel <= page[BW-1:0];
              s_addr  <= page_sidx;
              sbit    <= BW'(page_word);
              state   <= S_RMW;
            end else begin
              res_page  <= '0;
              res_found <= 1'b0;
              state     <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          if (sum_hit) begin
            w_addr   <= hit_word;
            s_addr   <= chk_addr;
            sbit     <= sum_k;
            sum_hold <= sum_rdata;
            state    <= S_WORD;
          end else if (chk_valid && last_sum) begin
            res_page  <= '0;
            res_found <= 1'b0;
            state     <= S_RESP;
          end else begin
            chk_valid <= 1'b1;
            chk_addr  <= scan_addr;
            if (scan_addr != SAW'(SW - 1)) begin
              scan_addr <= scan_addr + 1'b1;
            end
          end
        end
        S_WORD: begin
          res_page  <= bpa_pkg::PAGE_W'(pg_cat);
          res_found <= 1'b1;
          state     <= S_RESP;
        end
        S_RMW: begin
          res_page  <= '0;
          res_found <= 1'b1;
          state     <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            granted_page <= res_page;
            found        <= res_found;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/bpa_ram.sv]
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
